// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a plain property, off while in reset
`define IFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ibus frame decoder check failed");

// same-cycle implication
`define IFD_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ibus frame decoder check failed");

// next-cycle implication
`define IFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ibus frame decoder check failed");

`endif

// File: design/ifd_pkg.sv
`default_nettype none

package ifd_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN   = 32;
  localparam int unsigned SUM_LEN     = 30;
  localparam int unsigned FRAME_SLOTS = 14;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST     = 3'd0,
    REG_HEADER_SECOND    = 3'd1,
    REG_RANGE_LOW        = 3'd2,
    REG_RANGE_HIGH       = 3'd3,
    REG_THROTTLE_CHANNEL = 3'd4,
    REG_LOST_TIMEOUT     = 3'd5
  } reg_idx_e;

  // register reset values
  localparam logic [7:0]  RST_HEADER_FIRST     = 8'd32;
  localparam logic [7:0]  RST_HEADER_SECOND    = 8'd64;
  localparam logic [11:0] RST_RANGE_LOW        = 12'd900;
  localparam logic [11:0] RST_RANGE_HIGH       = 12'd2100;
  localparam logic [3:0]  RST_THROTTLE_CHANNEL = 4'd2;
  localparam logic [15:0] RST_LOST_TIMEOUT     = 16'd500;

  // fixed-point scaling: stick = (v - 1500) * 16384 / 500, throttle = (v - 1000) * 16384 / 1000
  localparam logic [11:0] STICK_CENTRE = 12'd1500;
  localparam logic [11:0] STICK_SPAN   = 12'd500;
  localparam logic [11:0] THR_BASE     = 12'd1000;
  localparam logic [11:0] THR_SPAN     = 12'd1000;
  localparam logic [14:0] Q_ONE        = 15'd16384;

  // floor(x / 125) for x below 2^21: reciprocal estimate plus one correction step
  localparam logic [6:0]  DIV_CONST   = 7'd125;
  localparam logic [14:0] DIV_RECIP   = 15'd16777;
  localparam int unsigned RECIP_SHIFT = 21;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_REJECT  = 2'd1,
    KIND_LINK    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_HEADER   = 2'd1,
    STATUS_BAD_CHECKSUM = 2'd2,
    STATUS_OUT_OF_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [11:0] range_low;
    logic [11:0] range_high;
    logic [3:0]  throttle_channel;
    logic [15:0] lost_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] frame_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [3:0]         channel_index;
    logic [11:0]        channel_value;
    logic signed [15:0] stick_position;
    logic [14:0]        throttle_fraction;
    logic               link_lost;
    logic               last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       issue;
    logic [3:0] issue_idx;
    logic       issue_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic can_take;
    logic frame_good;
    logic adv;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/ifd_stream_if.sv
`default_nettype none

interface ifd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/ifd_datapath.sv
`default_nettype none

module ifd_datapath #(
  parameter int unsigned NUM_CHANNELS = 14
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ifd_pkg::cfg_t        cfg_i,
  input  wire ifd_pkg::in_item_t    item_i,
  input  wire ifd_pkg::dp_cmd_t     cmd_i,
  output ifd_pkg::dp_status_t       status_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output ifd_pkg::out_item_t        out_item_o
);

  localparam int unsigned NACT =
    (NUM_CHANNELS < ifd_pkg::FRAME_SLOTS) ? NUM_CHANNELS : ifd_pkg::FRAME_SLOTS;
  localparam int unsigned IW = (NACT > 1) ? $clog2(NACT) : 1;

  // frame parsing state
  logic [5:0]       byte_count_q, byte_count_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       held_q, held_d;
  ifd_pkg::status_e ferr_q, ferr_d;
  logic             link_valid_q, link_valid_d;
  logic [15:0]      ms_q, ms_d;

  // staged channel values, written only from in-range words
  logic [11:0] chan_buf_q [NACT];

  // per-byte decode
  logic [5:0]       pos;
  logic [15:0]      sum_base;
  ifd_pkg::status_e ferr_base, ferr_hdr, ferr_new, err;
  logic             in_frame, hdr_bad, is_word, is_low, ch_active, range_bad;
  logic             is_final, chk_bad;
  logic [4:0]       ch_w;
  logic [3:0]       ch;
  logic [15:0]      word;
  logic             byte_take, tick_take, frame_bad, buf_we;
  logic [15:0]      ms_inc;
  logic             tick_lost, rej_lost;

  assign pos       = item_i.frame_start ? 6'd0 : byte_count_q;
  assign sum_base  = item_i.frame_start ? 16'd0 : sum_q;
  assign ferr_base = item_i.frame_start ? ifd_pkg::STATUS_OK : ferr_q;
  assign in_frame  = pos < 6'(ifd_pkg::FRAME_LEN);
  assign word      = {item_i.frame_byte, held_q};
  assign ch_w      = 5'(pos[5:1]) - 5'd1;
  assign ch        = ch_w[3:0];

  assign hdr_bad = ((pos == 6'd0) && (item_i.frame_byte != cfg_i.header_first)) ||
                   ((pos == 6'd1) && (item_i.frame_byte != cfg_i.header_second));
  assign is_word   = (pos >= 6'd2) && (pos < 6'(ifd_pkg::SUM_LEN)) && pos[0];
  assign is_low    = ((pos >= 6'd2) && (pos < 6'(ifd_pkg::SUM_LEN)) && !pos[0]) ||
                     (pos == 6'(ifd_pkg::SUM_LEN));
  assign ch_active = {1'b0, ch} < 5'(NACT);
  assign range_bad = (word < {4'b0, cfg_i.range_low}) || (word > {4'b0, cfg_i.range_high});
  assign is_final  = pos == 6'(ifd_pkg::FRAME_LEN - 1);
  assign chk_bad   = word != ~sum_base;

  // error priority: header, then checksum, then range
  always_comb begin
    ferr_hdr = ferr_base;
    if (ferr_base == ifd_pkg::STATUS_OK && hdr_bad) begin
      ferr_hdr = ifd_pkg::STATUS_BAD_HEADER;
    end
    ferr_new = ferr_hdr;
    if (is_word && ch_active && range_bad && ferr_hdr == ifd_pkg::STATUS_OK) begin
      ferr_new = ifd_pkg::STATUS_OUT_OF_RANGE;
    end
    priority if (ferr_new == ifd_pkg::STATUS_BAD_HEADER) begin
      err = ifd_pkg::STATUS_BAD_HEADER;
    end else if (chk_bad) begin
      err = ifd_pkg::STATUS_BAD_CHECKSUM;
    end else begin
      err = ferr_new;
    end
  end

  assign byte_take = cmd_i.accept && !item_i.mode;
  assign tick_take = cmd_i.accept && item_i.mode;
  assign frame_bad = byte_take && is_final && (err != ifd_pkg::STATUS_OK);
  assign buf_we    = byte_take && is_word && ch_active && !range_bad;

  assign ms_inc    = (ms_q == 16'hFFFF) ? ms_q : ms_q + 16'd1;
  assign tick_lost = !link_valid_q || (ms_inc > cfg_i.lost_timeout_ms);
  assign rej_lost  = !link_valid_q || (ms_q > cfg_i.lost_timeout_ms);

  // parsing and link state next values
  always_comb begin
    byte_count_d = byte_count_q;
    sum_d        = sum_q;
    held_d       = held_q;
    ferr_d       = ferr_q;
    link_valid_d = link_valid_q;
    ms_d         = ms_q;
    if (byte_take && in_frame) begin
      byte_count_d = pos + 6'd1;
      ferr_d       = ferr_new;
      sum_d        = (pos < 6'(ifd_pkg::SUM_LEN)) ? sum_base + {8'b0, item_i.frame_byte}
                                                  : sum_base;
      if (is_low) begin
        held_d = item_i.frame_byte;
      end
      if (is_final && err == ifd_pkg::STATUS_OK) begin
        link_valid_d = 1'b1;
        ms_d         = 16'd0;
      end
    end
    if (tick_take) begin
      ms_d = ms_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= 6'd0;
      sum_q        <= 16'd0;
      held_q       <= 8'd0;
      ferr_q       <= ifd_pkg::STATUS_OK;
      link_valid_q <= 1'b0;
      ms_q         <= 16'd0;
    end else begin
      byte_count_q <= byte_count_d;
      sum_q        <= sum_d;
      held_q       <= held_d;
      ferr_q       <= ferr_d;
      link_valid_q <= link_valid_d;
      ms_q         <= ms_d;
    end
  end

  // channel staging buffer
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      chan_buf_q[ch[IW-1:0]] <= word[11:0];
    end
  end

  // channel conversion pipeline: read, multiply, correct and clamp
  logic adv;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  logic [11:0] s1_val_q;
  logic [3:0]  s1_idx_q;
  logic        s1_last_q, s1_thr_q;

  logic [11:0] s2_val_q;
  logic [3:0]  s2_idx_q;
  logic        s2_last_q, s2_thr_q;
  logic        s2_sneg_q, s2_ssat_q, s2_tneg_q, s2_tsat_q;
  logic [20:0] s2_xs_q, s2_xt_q;
  logic [35:0] s2_ps_q, s2_pt_q;

  ifd_pkg::out_item_t out_q;

  assign adv = !out_valid_q || out_ready_i;

  // stage two operands
  logic        sneg, ssat, tneg, tsat;
  logic [11:0] smag, tdif;
  logic [20:0] xs, xt;
  logic [35:0] ps, pt;

  assign sneg = s1_val_q < ifd_pkg::STICK_CENTRE;
  assign smag = sneg ? ifd_pkg::STICK_CENTRE - s1_val_q : s1_val_q - ifd_pkg::STICK_CENTRE;
  assign ssat = smag >= ifd_pkg::STICK_SPAN;
  assign xs   = {smag[8:0], 12'b0};
  assign ps   = 36'(xs) * 36'(ifd_pkg::DIV_RECIP);

  assign tneg = s1_val_q < ifd_pkg::THR_BASE;
  assign tdif = s1_val_q - ifd_pkg::THR_BASE;
  assign tsat = tdif >= ifd_pkg::THR_SPAN;
  assign xt   = {tdif[9:0], 11'b0};
  assign pt   = 36'(xt) * 36'(ifd_pkg::DIV_RECIP);

  // stage three: quotient estimate is low by at most one
  logic [14:0] qs0, qt0, qs, qt, smag_q14, thr_frac;
  logic [21:0] rs, rt;
  logic signed [15:0] stick_pos, stick_abs;

  assign qs0 = s2_ps_q[ifd_pkg::RECIP_SHIFT +: 15];
  assign qt0 = s2_pt_q[ifd_pkg::RECIP_SHIFT +: 15];
  assign rs  = {1'b0, s2_xs_q} - 22'(qs0 * 22'(ifd_pkg::DIV_CONST));
  assign rt  = {1'b0, s2_xt_q} - 22'(qt0 * 22'(ifd_pkg::DIV_CONST));
  assign qs  = (rs >= 22'(ifd_pkg::DIV_CONST)) ? qs0 + 15'd1 : qs0;
  assign qt  = (rt >= 22'(ifd_pkg::DIV_CONST)) ? qt0 + 15'd1 : qt0;

  assign smag_q14  = s2_ssat_q ? ifd_pkg::Q_ONE : qs;
  assign stick_abs = $signed({1'b0, smag_q14});
  assign stick_pos = s2_sneg_q ? -stick_abs : stick_abs;

  always_comb begin
    priority if (!s2_thr_q || s2_tneg_q) begin
      thr_frac = 15'd0;
    end else if (s2_tsat_q) begin
      thr_frac = ifd_pkg::Q_ONE;
    end else begin
      thr_frac = qt;
    end
  end

  // pipeline valids and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_q  <= cmd_i.issue;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
      if (tick_take || frame_bad) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_val_q  <= chan_buf_q[cmd_i.issue_idx[IW-1:0]];
      s1_idx_q  <= cmd_i.issue_idx;
      s1_last_q <= cmd_i.issue_last;
      s1_thr_q  <= cmd_i.issue_idx == cfg_i.throttle_channel;

      s2_val_q  <= s1_val_q;
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;
      s2_thr_q  <= s1_thr_q;
      s2_sneg_q <= sneg;
      s2_ssat_q <= ssat;
      s2_tneg_q <= tneg;
      s2_tsat_q <= tsat;
      s2_xs_q   <= xs;
      s2_xt_q   <= xt;
      s2_ps_q   <= ps;
      s2_pt_q   <= pt;

      out_q.kind              <= ifd_pkg::KIND_CHANNEL;
      out_q.status            <= ifd_pkg::STATUS_OK;
      out_q.channel_index     <= s2_idx_q;
      out_q.channel_value     <= s2_val_q;
      out_q.stick_position    <= stick_pos;
      out_q.throttle_fraction <= thr_frac;
      out_q.link_lost         <= 1'b0;
      out_q.last              <= s2_last_q;
    end
    if (tick_take || frame_bad) begin
      out_q.kind              <= tick_take ? ifd_pkg::KIND_LINK : ifd_pkg::KIND_REJECT;
      out_q.status            <= tick_take ? ifd_pkg::STATUS_OK : err;
      out_q.channel_index     <= 4'd0;
      out_q.channel_value     <= 12'd0;
      out_q.stick_position    <= 16'sd0;
      out_q.throttle_fraction <= 15'd0;
      out_q.link_lost         <= tick_take ? tick_lost : rej_lost;
      out_q.last              <= 1'b1;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_item_o          = out_q;
  assign status_o.adv        = adv;
  assign status_o.can_take   = adv && !s1_valid_q && !s2_valid_q;
  assign status_o.frame_good = !item_i.mode && is_final && (err == ifd_pkg::STATUS_OK);

endmodule

`default_nettype wire

// File: design/ifd_ctrl.sv
`default_nettype none

module ifd_ctrl #(
  parameter int unsigned NUM_CHANNELS = 14
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ifd_pkg::dp_status_t status_i,
  output ifd_pkg::dp_cmd_t         cmd_o
);

  localparam int unsigned NACT =
    (NUM_CHANNELS < ifd_pkg::FRAME_SLOTS) ? NUM_CHANNELS : ifd_pkg::FRAME_SLOTS;
  localparam int unsigned IW = (NACT > 1) ? $clog2(NACT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } ctrl_state_e;

  ctrl_state_e   state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          accept, issue, cnt_last;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.can_take;
  assign accept     = in_valid_i && in_ready_o;
  assign issue      = (state_q == ST_EMIT) && status_i.adv;
  assign cnt_last   = cnt_q == IW'(NACT - 1);

  // sequencing of channel reads after a good frame
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && status_i.frame_good) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          if (cnt_last) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + IW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cmd_o.accept     = accept;
  assign cmd_o.issue      = issue;
  assign cmd_o.issue_idx  = 4'(cnt_q);
  assign cmd_o.issue_last = cnt_last;

endmodule

`default_nettype wire

// File: design/ibus_frame_decoder.sv
// Frame bytes are taken one per cycle while no channel results are pending and the output
// is not stalled; a tick or rejected frame gives its result in the output register in the
// cycle after it is taken. A good final byte starts a three-stage channel pipeline (buffer
// read, reciprocal multiply, correct and clamp) giving one result per cycle while the output
// is not stalled; no next item is taken until the pipeline has drained.
// Asynchronous active-low reset restores register defaults and clears parse and link state.
`default_nettype none
`include "assert_macros.svh"

module ibus_frame_decoder #(
  parameter int unsigned NUM_CHANNELS = 14
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ifd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ifd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ifd_stream_if.sink                            in_i,
  ifd_stream_if.source                          out_o
);

  ifd_pkg::cfg_t       cfg_q;
  ifd_pkg::dp_cmd_t    cmd;
  ifd_pkg::dp_status_t st;
  logic                in_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first     <= ifd_pkg::RST_HEADER_FIRST;
      cfg_q.header_second    <= ifd_pkg::RST_HEADER_SECOND;
      cfg_q.range_low        <= ifd_pkg::RST_RANGE_LOW;
      cfg_q.range_high       <= ifd_pkg::RST_RANGE_HIGH;
      cfg_q.throttle_channel <= ifd_pkg::RST_THROTTLE_CHANNEL;
      cfg_q.lost_timeout_ms  <= ifd_pkg::RST_LOST_TIMEOUT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ifd_pkg::REG_HEADER_FIRST:     cfg_q.header_first     <= cfg_data_i[7:0];
        ifd_pkg::REG_HEADER_SECOND:    cfg_q.header_second    <= cfg_data_i[7:0];
        ifd_pkg::REG_RANGE_LOW:        cfg_q.range_low        <= cfg_data_i[11:0];
        ifd_pkg::REG_RANGE_HIGH:       cfg_q.range_high       <= cfg_data_i[11:0];
        ifd_pkg::REG_THROTTLE_CHANNEL: cfg_q.throttle_channel <= cfg_data_i[3:0];
        ifd_pkg::REG_LOST_TIMEOUT:     cfg_q.lost_timeout_ms  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // frame sequencer
  ifd_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  // parsing, staging and conversion
  ifd_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (in_i.payload),
    .cmd_i       (cmd),
    .status_o    (st),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload)
  );

  assign in_i.ready = in_ready;

  // checks
  `IFD_ASSERT_IMPLIES(a_no_take_while_emit, cmd.issue, !in_ready)
  `IFD_ASSERT_IMPLIES(a_chan_link_ok, out_o.valid && out_o.payload.kind == ifd_pkg::KIND_CHANNEL, !out_o.payload.link_lost && out_o.payload.status == ifd_pkg::STATUS_OK)
  `IFD_ASSERT_IMPLIES(a_stick_bounds, out_o.valid, out_o.payload.stick_position <= 16'sd16384 && out_o.payload.stick_position >= -16'sd16384)
  `IFD_ASSERT_NEXT(a_tick_reports, in_i.valid && in_ready && in_i.payload.mode, out_o.valid && out_o.payload.kind == ifd_pkg::KIND_LINK && out_o.payload.last)
  `IFD_ASSERT(a_accept_clear_pipe, !(cmd.accept && !st.can_take))

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top;
  import ifd_pkg::*;

  localparam int unsigned CHANNELS     = 14;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ifd_stream_if #(.payload_t(in_item_t))  byte_if ();
  ifd_stream_if #(.payload_t(out_item_t)) result_if ();

  ibus_frame_decoder #(
    .NUM_CHANNELS(CHANNELS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (byte_if),
    .out_o      (result_if)
  );

  always #5 clk_i = ~clk_i;

  // decoder state mirrored in the testbench
  cfg_t        model_cfg;
  logic [5:0]  byte_pos;
  logic [15:0] byte_sum;
  logic [7:0]  low_byte;
  status_e     first_fault;
  logic [11:0] staged_value [CHANNELS];
  logic        link_seen;
  logic [15:0] ms_idle;

  // decoded results still to come out of the block
  out_item_t   awaited_results [$];

  int unsigned fail_count;
  int unsigned sent_items;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_off;

  // frame under construction
  logic [15:0] chan_words [CHANNELS];
  logic [7:0]  frame_buf [FRAME_LEN];

  function automatic void model_reset();
    model_cfg.header_first     = RST_HEADER_FIRST;
    model_cfg.header_second    = RST_HEADER_SECOND;
    model_cfg.range_low        = RST_RANGE_LOW;
    model_cfg.range_high       = RST_RANGE_HIGH;
    model_cfg.throttle_channel = RST_THROTTLE_CHANNEL;
    model_cfg.lost_timeout_ms  = RST_LOST_TIMEOUT;
    byte_pos    = '0;
    byte_sum    = '0;
    low_byte    = '0;
    first_fault = STATUS_OK;
    link_seen   = 1'b0;
    ms_idle     = '0;
    for (int i = 0; i < CHANNELS; i++) staged_value[i] = '0;
  endfunction

  function automatic logic link_is_lost();
    return !link_seen || (ms_idle > model_cfg.lost_timeout_ms);
  endfunction

  function automatic out_item_t pack_result(kind_e k, status_e s, logic [3:0] idx,
                                            logic [11:0] val, logic signed [15:0] stick,
                                            logic [14:0] thr, logic lost, logic fin);
    out_item_t r;
    r.kind              = k;
    r.status            = s;
    r.channel_index     = idx;
    r.channel_value     = val;
    r.stick_position    = stick;
    r.throttle_fraction = thr;
    r.link_lost         = lost;
    r.last              = fin;
    return r;
  endfunction

  // works out the results of one accepted byte or tick
  function automatic void decode_item(in_item_t it);
    int          at;
    int          ch;
    logic [15:0] word;
    logic [15:0] wanted;
    status_e     verdict;
    int          v;
    int          stick;
    int          thr;

    // millisecond tick: link status
    if (it.mode) begin
      if (ms_idle != 16'hFFFF) ms_idle++;
      awaited_results.push_back(pack_result(KIND_LINK, STATUS_OK, '0, '0, '0, '0,
                                            link_is_lost(), 1'b1));
      return;
    end

    if (it.frame_start) begin
      byte_pos    = '0;
      byte_sum    = '0;
      first_fault = STATUS_OK;
    end
    if (byte_pos >= FRAME_LEN) return;
    at       = int'(byte_pos);
    byte_pos = byte_pos + 6'd1;

    // header bytes
    if (at == 0 && it.frame_byte != model_cfg.header_first && first_fault == STATUS_OK)
      first_fault = STATUS_BAD_HEADER;
    if (at == 1 && it.frame_byte != model_cfg.header_second && first_fault == STATUS_OK)
      first_fault = STATUS_BAD_HEADER;

    if (at < SUM_LEN) byte_sum = byte_sum + 16'(it.frame_byte);

    // channel words, range checked as they complete
    if (at >= 2 && at < SUM_LEN) begin
      if (at % 2 == 0) begin
        low_byte = it.frame_byte;
      end else begin
        ch   = (at - 2) / 2;
        word = {it.frame_byte, low_byte};
        if (ch < CHANNELS) begin
          if (word < 16'(model_cfg.range_low) || word > 16'(model_cfg.range_high)) begin
            if (first_fault == STATUS_OK) first_fault = STATUS_OUT_OF_RANGE;
          end else begin
            staged_value[ch] = word[11:0];
          end
        end
      end
      return;
    end

    if (at == 30) begin
      low_byte = it.frame_byte;
      return;
    end
    if (at != 31) return;

    // final byte: verdict on the whole frame
    word   = {it.frame_byte, low_byte};
    wanted = 16'hFFFF - byte_sum;
    if (first_fault == STATUS_BAD_HEADER) verdict = STATUS_BAD_HEADER;
    else if (word != wanted) verdict = STATUS_BAD_CHECKSUM;
    else verdict = first_fault;

    if (verdict != STATUS_OK) begin
      awaited_results.push_back(pack_result(KIND_REJECT, verdict, '0, '0, '0, '0,
                                            link_is_lost(), 1'b1));
      return;
    end

    link_seen = 1'b1;
    ms_idle   = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      v     = int'(staged_value[i]);
      stick = ((v - 1500) * 16384) / 500;
      if (stick > 16384) stick = 16384;
      if (stick < -16384) stick = -16384;
      thr = 0;
      if (i == int'(model_cfg.throttle_channel)) begin
        thr = ((v - 1000) * 16384) / 1000;
        if (thr > 16384) thr = 16384;
        if (thr < 0) thr = 0;
      end
      awaited_results.push_back(pack_result(KIND_CHANNEL, STATUS_OK, 4'(i), staged_value[i],
                                            stick[15:0], thr[14:0], 1'b0,
                                            i == CHANNELS - 1));
    end
  endfunction

  // compare one result transaction against the oldest expectation
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: kind %0d status %0d channel_index %0d",
             got.kind, got.status, got.channel_index);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
      if (got.channel_index !== want.channel_index) begin
        $error("channel_index: expected %0d, got %0d", want.channel_index, got.channel_index);
        fail_count++;
      end
      if (got.channel_value !== want.channel_value) begin
        $error("channel_value: expected %0d, got %0d", want.channel_value, got.channel_value);
        fail_count++;
      end
      if (got.stick_position !== want.stick_position) begin
        $error("stick_position: expected %0d, got %0d", want.stick_position,
               got.stick_position);
        fail_count++;
      end
      if (got.throttle_fraction !== want.throttle_fraction) begin
        $error("throttle_fraction: expected %0d, got %0d", want.throttle_fraction,
               got.throttle_fraction);
        fail_count++;
      end
      if (got.link_lost !== want.link_lost) begin
        $error("link_lost: expected %0d, got %0d", want.link_lost, got.link_lost);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fail_count++;
      end
    end
  endtask

  // result side: check each transaction, stall at random or on hold-off
  always @(posedge clk_i) begin
    if (result_if.valid && result_if.ready) check_result(result_if.payload);
    result_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // offer one item, with random idle cycles first, until it is taken
  task automatic push_item(input logic mode, input logic [7:0] value, input logic start);
    in_item_t it;
    it.mode        = mode;
    it.frame_byte  = value;
    it.frame_start = start;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.payload <= it;
    byte_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!byte_if.ready);
    decode_item(it);
    sent_items++;
  endtask

  task automatic push_tick();
    push_item(1'b1, 8'($urandom), 1'($urandom));
  endtask

  // wait until every expected result has come out
  task automatic drain_results();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic settle();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic drive_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // write all six registers, block idle
  task automatic set_config(input cfg_t c);
    drive_reg(REG_HEADER_FIRST, 16'(c.header_first));
    drive_reg(REG_HEADER_SECOND, 16'(c.header_second));
    drive_reg(REG_RANGE_LOW, 16'(c.range_low));
    drive_reg(REG_RANGE_HIGH, 16'(c.range_high));
    drive_reg(REG_THROTTLE_CHANNEL, 16'(c.throttle_channel));
    drive_reg(REG_LOST_TIMEOUT, c.lost_timeout_ms);
    cfg_we_i  <= 1'b0;
    model_cfg = c;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  function automatic logic [15:0] in_range_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return 16'(model_cfg.range_low);
    if (pick < 30) return 16'(model_cfg.range_high);
    return 16'($urandom_range(model_cfg.range_high, model_cfg.range_low));
  endfunction

  function automatic logic [15:0] out_range_word();
    if (model_cfg.range_low != 0 && $urandom_range(1) == 1)
      return 16'($urandom_range(model_cfg.range_low - 1, 0));
    return 16'($urandom_range(65535, model_cfg.range_high + 1));
  endfunction

  task automatic pick_good_words();
    for (int i = 0; i < CHANNELS; i++) chan_words[i] = in_range_word();
  endtask

  // lay out headers, channel words and checksum, optionally corrupting the checksum
  task automatic assemble_frame(input logic [7:0] hdr0, input logic [7:0] hdr1,
                                input bit bad_sum);
    logic [15:0] total;
    logic [15:0] csum;
    frame_buf[0] = hdr0;
    frame_buf[1] = hdr1;
    for (int i = 0; i < CHANNELS; i++) begin
      frame_buf[2 + 2 * i] = chan_words[i][7:0];
      frame_buf[3 + 2 * i] = chan_words[i][15:8];
    end
    total = '0;
    for (int i = 0; i < SUM_LEN; i++) total = total + 16'(frame_buf[i]);
    csum = 16'hFFFF - total;
    if (bad_sum) csum = csum ^ (16'd1 << $urandom_range(15));
    frame_buf[30] = csum[7:0];
    frame_buf[31] = csum[15:8];
  endtask

  // send the first len bytes, ticks slipped in between at random
  task automatic send_frame(input int unsigned len, input int unsigned tick_pct,
                            input bit mark_start);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < tick_pct) push_tick();
      push_item(1'b0, frame_buf[i], (i == 0) && mark_start);
    end
  endtask

  task automatic good_frame(input int unsigned tick_pct);
    pick_good_words();
    assemble_frame(model_cfg.header_first, model_cfg.header_second, 1'b0);
    send_frame(FRAME_LEN, tick_pct, 1'b1);
  endtask

  // mostly well-formed frames with random content, the rest faults and noise
  task automatic random_traffic(input int unsigned amount);
    int unsigned first_count;
    int unsigned pick;
    first_count = sent_items;
    while (sent_items - first_count < amount) begin
      pick = $urandom_range(99);
      pick_good_words();
      if (pick < 55) begin
        assemble_frame(model_cfg.header_first, model_cfg.header_second, 1'b0);
        send_frame(FRAME_LEN, 4, 1'b1);
      end else if (pick < 63) begin
        // header fault, perhaps with others behind it
        if ($urandom_range(1) == 1) chan_words[$urandom_range(CHANNELS - 1)] = out_range_word();
        if ($urandom_range(1) == 1)
          assemble_frame(model_cfg.header_first ^ 8'($urandom_range(255, 1)),
                         model_cfg.header_second, 1'($urandom_range(1)));
        else
          assemble_frame(model_cfg.header_first,
                         model_cfg.header_second ^ 8'($urandom_range(255, 1)),
                         1'($urandom_range(1)));
        send_frame(FRAME_LEN, 4, 1'b1);
      end else if (pick < 71) begin
        if ($urandom_range(1) == 1) chan_words[$urandom_range(CHANNELS - 1)] = out_range_word();
        assemble_frame(model_cfg.header_first, model_cfg.header_second, 1'b1);
        send_frame(FRAME_LEN, 4, 1'b1);
      end else if (pick < 79) begin
        repeat ($urandom_range(3, 1)) chan_words[$urandom_range(CHANNELS - 1)] = out_range_word();
        assemble_frame(model_cfg.header_first, model_cfg.header_second, 1'b0);
        send_frame(FRAME_LEN, 4, 1'b1);
      end else if (pick < 85) begin
        // cut short, or trailing bytes past the end
        assemble_frame(model_cfg.header_first, model_cfg.header_second, 1'b0);
        if ($urandom_range(1) == 1) begin
          send_frame($urandom_range(FRAME_LEN - 1, 1), 4, 1'b1);
        end else begin
          send_frame(FRAME_LEN, 4, 1'b1);
          repeat ($urandom_range(3, 1)) push_item(1'b0, 8'($urandom), 1'b0);
        end
      end else if (pick < 95) begin
        repeat ($urandom_range(4, 1)) push_tick();
      end else begin
        repeat ($urandom_range(6, 1)) push_item(1'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    // status with no good frame yet
    push_item(1'b1, 8'hFF, 1'b1);
    push_item(1'b1, 8'h00, 1'b0);
    // range edges and clamp points; byte 0 unmarked, counting from reset
    chan_words = '{16'd900, 16'd2100, 16'd1000, 16'd1500, 16'd2000, 16'd901, 16'd1499,
                   16'd1501, 16'd999, 16'd1250, 16'd1750, 16'd2099, 16'd1100, 16'd1900};
    assemble_frame(model_cfg.header_first, model_cfg.header_second, 1'b0);
    send_frame(FRAME_LEN, 0, 1'b0);
    push_tick();
    // bytes after the end of a frame are dropped
    repeat (3) push_item(1'b0, 8'($urandom), 1'b0);
    // header faults on either byte; header outranks checksum
    pick_good_words();
    assemble_frame(model_cfg.header_first ^ 8'h01, model_cfg.header_second, 1'b0);
    send_frame(FRAME_LEN, 0, 1'b1);
    assemble_frame(model_cfg.header_first, model_cfg.header_second ^ 8'h80, 1'b1);
    send_frame(FRAME_LEN, 0, 1'b1);
    // checksum outranks out of range
    chan_words[5] = 16'hFFFF;
    assemble_frame(model_cfg.header_first, model_cfg.header_second, 1'b1);
    send_frame(FRAME_LEN, 0, 1'b1);
    // just below and just above the window
    pick_good_words();
    chan_words[0] = 16'd899;
    assemble_frame(model_cfg.header_first, model_cfg.header_second, 1'b0);
    send_frame(FRAME_LEN, 0, 1'b1);
    pick_good_words();
    chan_words[CHANNELS - 1] = 16'd2101;
    assemble_frame(model_cfg.header_first, model_cfg.header_second, 1'b0);
    send_frame(FRAME_LEN, 0, 1'b1);
    // frame abandoned midway, then restarted
    pick_good_words();
    assemble_frame(model_cfg.header_first, model_cfg.header_second, 1'b0);
    send_frame(10, 0, 1'b1);
    good_frame(0);
    push_tick();
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    settle();
    c.header_first     = 8'h00;
    c.header_second    = 8'hFF;
    c.range_low        = 12'd0;
    c.range_high       = 12'd4095;
    c.throttle_channel = 4'd13;
    c.lost_timeout_ms  = 16'd0;
    set_config(c);
    // full-scale words, both stick clamps and the upper throttle clamp
    chan_words = '{16'd0, 16'd4095, 16'd1, 16'd1000, 16'd1500, 16'd2000, 16'd2001,
                   16'd999, 16'd3000, 16'd4094, 16'd500, 16'd2500, 16'd1250, 16'd4095};
    assemble_frame(c.header_first, c.header_second, 1'b0);
    send_frame(FRAME_LEN, 0, 1'b1);
    push_tick();
    push_tick();
    random_traffic(40);

    settle();
    c.header_first     = 8'hFF;
    c.header_second    = 8'h00;
    c.range_low        = 12'd1500;
    c.range_high       = 12'd1500;
    c.throttle_channel = 4'd0;
    c.lost_timeout_ms  = 16'd65535;
    set_config(c);
    random_traffic(40);

    // inverted window: nothing can pass
    settle();
    c.range_low        = 12'd4095;
    c.range_high       = 12'd0;
    c.throttle_channel = 4'd7;
    c.lost_timeout_ms  = 16'd3;
    set_config(c);
    good_frame(10);
    good_frame(10);
    random_traffic(20);
  endtask

  task automatic test_tick_saturation();
    cfg_t c;
    settle();
    set_idling(0, 0);
    c.header_first     = RST_HEADER_FIRST;
    c.header_second    = RST_HEADER_SECOND;
    c.range_low        = RST_RANGE_LOW;
    c.range_high       = RST_RANGE_HIGH;
    c.throttle_channel = RST_THROTTLE_CHANNEL;
    c.lost_timeout_ms  = 16'd65534;
    set_config(c);
    // idle counter runs past its top and holds there
    good_frame(0);
    repeat (65537) push_tick();
    settle();
    c.lost_timeout_ms = 16'd65535;
    set_config(c);
    push_tick();
    push_tick();
  endtask

  task automatic test_backpressure();
    settle();
    set_idling(0, 0);
    // result side held off while frames keep coming
    fork
      begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        good_frame(0);
        good_frame(0);
        repeat (6) push_tick();
      end
    join
  endtask

  task automatic test_sender_pause();
    set_idling(0, 0);
    good_frame(3);
    drain_results();
    good_frame(3);
    push_tick();
  endtask

  task automatic test_idle_phases();
    int unsigned send_pct [4];
    int unsigned recv_pct [4];
    cfg_t        c;
    send_pct = '{0, 52, 0, 23};
    recv_pct = '{0, 0, 52, 23};
    for (int p = 0; p < 4; p++) begin
      settle();
      c.header_first     = 8'($urandom);
      c.header_second    = 8'($urandom);
      c.range_low        = 12'($urandom_range(1200, 800));
      c.range_high       = 12'($urandom_range(2200, 1800));
      c.throttle_channel = 4'($urandom_range(CHANNELS - 1));
      c.lost_timeout_ms  = 16'($urandom_range(8));
      set_config(c);
      set_idling(send_pct[p], recv_pct[p]);
      random_traffic(75);
    end
    set_idling(0, 0);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_HEADER_FIRST;
    cfg_data_i      = '0;
    byte_if.valid   = 1'b0;
    byte_if.payload = '0;
    result_if.ready = 1'b0;
    hold_off        = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    fail_count      = 0;
    sent_items      = 0;
    model_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_tick_saturation();
    test_backpressure();
    test_sender_pause();
    test_idle_phases();

    settle();
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// File: ibus_frame_decoder.f
+incdir+design
design/ifd_pkg.sv
design/ifd_stream_if.sv
design/ifd_datapath.sv
design/ifd_ctrl.sv
design/ibus_frame_decoder.sv
sim/tb_top.sv
